// ----- rtl/wpls_pkg.sv -----
`timescale 1ns / 1ps

package wpls_pkg;

  localparam int CHAINS_DEFAULT      = 16;
  localparam int SLOTS_DEFAULT       = 8;
  localparam int SAMPLE_BITS_DEFAULT = 16;

  localparam int CHAIN_SEL_W = 4;
  localparam int GAIN_W      = 11;
  localparam int WIN_W       = 27;
  localparam int POS_W       = 32;
  localparam int SOURCE_W    = 31;
  localparam int SLOT_OUT_W  = 3;
  localparam int LEVEL_W     = 17;
  localparam int COUNT_W     = 32;
  localparam int STATUS_W    = 2;
  localparam int CFG_DATA_W  = 27;
  localparam int CFG_INDEX_W = 3;

  localparam int LEVEL_MAX   = 65536;
  localparam int DIV_BASE    = 1000;
  localparam int SAT_LIMIT   = (LEVEL_MAX + 1) * DIV_BASE;
  localparam int DIV_W       = 26;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_CHAIN_SELECT = 3'd0,
    REG_GAIN         = 3'd1,
    REG_OFFSET       = 3'd2,
    REG_DURATION     = 3'd3,
    REG_STEREO       = 3'd4
  } reg_index_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_UPDATED = 2'd0,
    ST_TAKEN   = 2'd1,
    ST_DROPPED = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_SCAN,
    BK_WRITE
  } bk_state_t;

  typedef struct packed {
    logic [CHAIN_SEL_W-1:0] chain_select;
    logic [GAIN_W-1:0]      gain_tenths_percent;
    logic [WIN_W-1:0]       win_offset;
    logic [WIN_W-1:0]       duration_samples;
    logic                   stereo;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    chain_select:        '0,
    gain_tenths_percent: GAIN_W'(1000),
    win_offset:          '0,
    duration_samples:    '0,
    stereo:              1'b1
  };

endpackage

// ----- rtl/wpls_front.sv -----
`timescale 1ns / 1ps

module wpls_front #(
  parameter int CHAINS      = wpls_pkg::CHAINS_DEFAULT,
  parameter int SAMPLE_BITS = wpls_pkg::SAMPLE_BITS_DEFAULT,
  parameter int CW          = 1,
  parameter int EW          = 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  wpls_pkg::cfg_t                     cfg,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [SAMPLE_BITS-1:0]      sample_left,
  input  logic signed [SAMPLE_BITS-1:0]      sample_right,
  input  logic [wpls_pkg::POS_W-1:0]         sample_position,
  input  logic [wpls_pkg::SOURCE_W-1:0]      source_id,
  input  logic                               chunk_last,
  input  logic                               q_full,
  output logic                               push,
  output logic [EW-1:0]                      push_data
);

  logic [SAMPLE_BITS-1:0]      running_peak;
  logic                        any_in_window;
  logic [SAMPLE_BITS-1:0]      abs_l;
  logic [SAMPLE_BITS-1:0]      abs_r;
  logic [SAMPLE_BITS-1:0]      abs_max;
  logic [SAMPLE_BITS-1:0]      peak_c;
  logic                        any_c;
  logic [wpls_pkg::WIN_W:0]    win_hi;
  logic                        in_win;
  logic                        chain_ok;
  logic                        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    abs_l   = sample_left[SAMPLE_BITS-1] ? SAMPLE_BITS'(~sample_left + 1'b1) : sample_left;
    abs_r   = sample_right[SAMPLE_BITS-1] ? SAMPLE_BITS'(~sample_right + 1'b1) : sample_right;
    abs_max = (cfg.stereo && abs_r > abs_l) ? abs_r : abs_l;
    win_hi  = {1'b0, cfg.win_offset} + {1'b0, cfg.duration_samples};
    in_win  = (wpls_pkg::POS_W'(cfg.win_offset) <= sample_position) &&
              (cfg.duration_samples == '0 ||
               sample_position < wpls_pkg::POS_W'(win_hi));
    peak_c  = (in_win && abs_max > running_peak) ? abs_max : running_peak;
    any_c   = any_in_window || in_win;
    chain_ok = 32'(cfg.chain_select) < 32'(CHAINS);
  end

  assign push      = accept && chunk_last && any_c && chain_ok;
  assign push_data = {peak_c, source_id, CW'(cfg.chain_select)};

  always_ff @(posedge clk) begin
    if (rst) begin
      running_peak  <= '0;
      any_in_window <= 1'b0;
    end else if (accept) begin
      if (chunk_last) begin
        running_peak  <= '0;
        any_in_window <= 1'b0;
      end else begin
        running_peak  <= peak_c;
        any_in_window <= any_c;
      end
    end
  end

endmodule

// ----- rtl/wpls_queue.sv -----
`timescale 1ns / 1ps

module wpls_queue #(
  parameter int W = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  output logic         avail,
  input  logic         pop,
  output logic [W-1:0] pop_data
);

  localparam int DEPTH = wpls_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  logic [W-1:0]  entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;

  assign full     = count == NW'(DEPTH);
  assign avail    = count != '0;
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) pop |-> avail)
    else $error("queue popped while empty");
  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue pushed while full");

endmodule

// ----- rtl/wpls_back.sv -----
`timescale 1ns / 1ps

module wpls_back #(
  parameter int CHAINS      = wpls_pkg::CHAINS_DEFAULT,
  parameter int SLOTS       = wpls_pkg::SLOTS_DEFAULT,
  parameter int SAMPLE_BITS = wpls_pkg::SAMPLE_BITS_DEFAULT,
  parameter int CW          = 1,
  parameter int EW          = 1
) (
  input  logic                               clk,
  input  logic                               rst,
  input  wpls_pkg::cfg_t                     cfg,
  input  logic                               q_avail,
  input  logic [EW-1:0]                      q_data,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [wpls_pkg::SLOT_OUT_W-1:0]    slot,
  output logic [wpls_pkg::LEVEL_W-1:0]       level,
  output logic [wpls_pkg::COUNT_W-1:0]       write_count,
  output logic [wpls_pkg::STATUS_W-1:0]      status
);

  localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int DEPTH = CHAINS * SLOTS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int PW    = SAMPLE_BITS + wpls_pkg::GAIN_W;
  localparam int DW    = (PW > wpls_pkg::DIV_W) ? PW : wpls_pkg::DIV_W;
  localparam int LW    = wpls_pkg::LEVEL_W;
  localparam int RS    = DW + $clog2(wpls_pkg::DIV_BASE);
  localparam int MW    = DW + 1;
  localparam int RW    = 2 * DW + 1;
  localparam logic [MW-1:0] RM =
    MW'(((64'd1 << RS) + 64'(wpls_pkg::DIV_BASE) - 64'd1) / 64'(wpls_pkg::DIV_BASE));

  logic [wpls_pkg::SOURCE_W-1:0] src_mem [DEPTH];
  logic [LW-1:0]                 lvl_mem [DEPTH];
  logic [wpls_pkg::COUNT_W-1:0]  upd_mem [DEPTH];
  logic [DEPTH-1:0]              in_use;

  wpls_pkg::bk_state_t state;
  wpls_pkg::bk_state_t state_next;

  logic [SAMPLE_BITS-1:0]        q_peak;
  logic [wpls_pkg::SOURCE_W-1:0] q_src;
  logic [CW-1:0]                 q_chain;
  logic [PW-1:0]                 mul;

  logic [DW-1:0]                 prod;
  logic [RW-1:0]                 recip;
  logic [LW-1:0]                 quo;
  logic [wpls_pkg::SOURCE_W-1:0] src_r;
  logic [AW-1:0]                 base_r;
  logic [SW-1:0]                 scan_idx;
  logic                          issue_done;
  logic                          cmp_valid;
  logic [SW-1:0]                 cmp_idx;
  logic                          free_found;
  logic [SW-1:0]                 first_free;
  logic [wpls_pkg::SOURCE_W-1:0] rd_src;
  logic [wpls_pkg::COUNT_W-1:0]  rd_upd;
  logic [SW-1:0]                 res_slot;
  wpls_pkg::status_t             res_status;
  logic [wpls_pkg::COUNT_W-1:0]  res_count;
  logic [LW-1:0]                 level_val;

  logic [AW-1:0]                 rd_addr;
  logic [AW-1:0]                 cmp_addr;
  logic [AW-1:0]                 wr_addr;
  logic                          hit;
  logic                          cmp_last;
  logic                          out_load;
  logic                          mem_we;

  assign {q_peak, q_src, q_chain} = q_data;
  assign mul       = PW'(q_peak) * PW'(cfg.gain_tenths_percent);
  assign quo       = recip[RS +: LW];
  assign rd_addr   = base_r + AW'(scan_idx);
  assign cmp_addr  = base_r + AW'(cmp_idx);
  assign wr_addr   = base_r + AW'(res_slot);
  assign hit       = in_use[cmp_addr] && (rd_src == src_r);
  assign cmp_last  = cmp_idx == SW'(SLOTS - 1);
  assign level_val = (prod >= DW'(wpls_pkg::SAT_LIMIT)) ? LW'(wpls_pkg::LEVEL_MAX) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wpls_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    mem_we     = 1'b0;
    unique case (state)
      wpls_pkg::BK_IDLE: begin
        if (q_avail) begin
          q_pop      = 1'b1;
          state_next = wpls_pkg::BK_DIV;
        end
      end
      wpls_pkg::BK_DIV: begin
        state_next = wpls_pkg::BK_SCAN;
      end
      wpls_pkg::BK_SCAN: begin
        if (cmp_valid && (hit || cmp_last)) begin
          state_next = wpls_pkg::BK_WRITE;
        end
      end
      wpls_pkg::BK_WRITE: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          mem_we     = res_status != wpls_pkg::ST_DROPPED;
          state_next = wpls_pkg::BK_IDLE;
        end
      end
      default: state_next = wpls_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    rd_src <= src_mem[rd_addr];
    rd_upd <= upd_mem[rd_addr];
    if (mem_we) begin
      src_mem[wr_addr] <= src_r;
      lvl_mem[wr_addr] <= level_val;
      upd_mem[wr_addr] <= res_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_use <= '0;
    end else if (mem_we) begin
      in_use[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      prod       <= DW'(mul);
      src_r      <= q_src;
      base_r     <= AW'(q_chain) * AW'(SLOTS);
      scan_idx   <= '0;
      issue_done <= 1'b0;
      cmp_valid  <= 1'b0;
      free_found <= 1'b0;
    end
    if (state == wpls_pkg::BK_DIV) begin
      recip <= RW'(prod) * RW'(RM);
    end
    if (state == wpls_pkg::BK_SCAN) begin
      if (!issue_done) begin
        scan_idx   <= scan_idx + 1'b1;
        issue_done <= scan_idx == SW'(SLOTS - 1);
      end
      cmp_valid <= !issue_done;
      cmp_idx   <= scan_idx;
      if (cmp_valid) begin
        if (!in_use[cmp_addr] && !free_found) begin
          free_found <= 1'b1;
          first_free <= cmp_idx;
        end
        if (hit) begin
          res_slot   <= cmp_idx;
          res_status <= wpls_pkg::ST_UPDATED;
          res_count  <= rd_upd + 1'b1;
        end else if (cmp_last) begin
          if (free_found) begin
            res_slot   <= first_free;
            res_status <= wpls_pkg::ST_TAKEN;
            res_count  <= wpls_pkg::COUNT_W'(1);
          end else if (!in_use[cmp_addr]) begin
            res_slot   <= cmp_idx;
            res_status <= wpls_pkg::ST_TAKEN;
            res_count  <= wpls_pkg::COUNT_W'(1);
          end else begin
            res_slot   <= '0;
            res_status <= wpls_pkg::ST_DROPPED;
            res_count  <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      slot        <= wpls_pkg::SLOT_OUT_W'(res_slot);
      level       <= level_val;
      write_count <= res_count;
      status      <= res_status;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    (state == wpls_pkg::BK_WRITE && res_status == wpls_pkg::ST_DROPPED)
      |-> (res_count == '0 && res_slot == '0))
    else $error("dropped request carries a slot or count");
  assert property (@(posedge clk) disable iff (rst)
    (mem_we && res_status == wpls_pkg::ST_TAKEN) |-> !in_use[wr_addr])
    else $error("taken slot was already in use");
  assert property (@(posedge clk) disable iff (rst)
    (mem_we && res_status == wpls_pkg::ST_UPDATED) |-> in_use[wr_addr])
    else $error("updated slot was not in use");

endmodule

// ----- rtl/windowed_peak_level_send.sv -----
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// in        in_valid / in_ready    sample_left, sample_right, sample_position,
//                                  source_id, chunk_last
// out       out_valid / out_ready  slot, level, write_count, status
// cfg       cfg_we                 cfg_index, cfg_data
//
// One sample is taken per cycle while the queue is not full; peak tracking is combinational.
// The table engine handles one request at a time: a reciprocal multiply for the divide
// by 1000, then one slot-table read per slot up to a source match or the last slot.
// Two requests queue between peak tracker and table engine; input stalls only
// when that queue is full. A finished result waits in the output register.
// Reset is synchronous and clears the slot valid bits at once.

module windowed_peak_level_send #(
  parameter int CHAINS      = wpls_pkg::CHAINS_DEFAULT,
  parameter int SLOTS       = wpls_pkg::SLOTS_DEFAULT,
  parameter int SAMPLE_BITS = wpls_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [wpls_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [wpls_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [SAMPLE_BITS-1:0]         sample_left,
  input  logic signed [SAMPLE_BITS-1:0]         sample_right,
  input  logic [wpls_pkg::POS_W-1:0]            sample_position,
  input  logic [wpls_pkg::SOURCE_W-1:0]         source_id,
  input  logic                                  chunk_last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [wpls_pkg::SLOT_OUT_W-1:0]       slot,
  output logic [wpls_pkg::LEVEL_W-1:0]          level,
  output logic [wpls_pkg::COUNT_W-1:0]          write_count,
  output logic [wpls_pkg::STATUS_W-1:0]         status
);

  localparam int CW = (CHAINS > 1) ? $clog2(CHAINS) : 1;
  localparam int EW = SAMPLE_BITS + wpls_pkg::SOURCE_W + CW;

  wpls_pkg::cfg_t cfg;
  logic           push;
  logic [EW-1:0]  push_data;
  logic           q_full;
  logic           q_avail;
  logic           q_pop;
  logic [EW-1:0]  q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= wpls_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        wpls_pkg::REG_CHAIN_SELECT:
          cfg.chain_select <= cfg_data[wpls_pkg::CHAIN_SEL_W-1:0];
        wpls_pkg::REG_GAIN:
          cfg.gain_tenths_percent <= cfg_data[wpls_pkg::GAIN_W-1:0];
        wpls_pkg::REG_OFFSET:
          cfg.win_offset <= cfg_data[wpls_pkg::WIN_W-1:0];
        wpls_pkg::REG_DURATION:
          cfg.duration_samples <= cfg_data[wpls_pkg::WIN_W-1:0];
        wpls_pkg::REG_STEREO:
          cfg.stereo <= cfg_data[0];
        default: ;
      endcase
    end
  end

  wpls_front #(
    .CHAINS      (CHAINS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CW          (CW),
    .EW          (EW)
  ) u_front (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .sample_left     (sample_left),
    .sample_right    (sample_right),
    .sample_position (sample_position),
    .source_id       (source_id),
    .chunk_last      (chunk_last),
    .q_full          (q_full),
    .push            (push),
    .push_data       (push_data)
  );

  wpls_queue #(
    .W (EW)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .avail     (q_avail),
    .pop       (q_pop),
    .pop_data  (q_data)
  );

  wpls_back #(
    .CHAINS      (CHAINS),
    .SLOTS       (SLOTS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .CW          (CW),
    .EW          (EW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_avail      (q_avail),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .slot         (slot),
    .level        (level),
    .write_count  (write_count),
    .status       (status)
  );

endmodule
